@@ hw/rtl/bp2rgba_pkg.sv @@
package bp2rgba_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_IDX_W   = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int NUM_CH      = 4;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [31:0] RECIP_1   = 32'hFFFF_FFFF;
    localparam logic [31:0] RECIP_3   = 32'((64'd1 << 32) / 64'd3);
    localparam logic [31:0] RECIP_7   = 32'((64'd1 << 32) / 64'd7);
    localparam logic [31:0] RECIP_15  = 32'((64'd1 << 32) / 64'd15);
    localparam logic [31:0] RECIP_31  = 32'((64'd1 << 32) / 64'd31);
    localparam logic [31:0] RECIP_63  = 32'((64'd1 << 32) / 64'd63);
    localparam logic [31:0] RECIP_127 = 32'((64'd1 << 32) / 64'd127);

    typedef enum logic [2:0] {
        REG_PALETTE_MODE    = 3'd0,
        REG_BYTES_PER_PIXEL = 3'd1,
        REG_RED_MASK        = 3'd2,
        REG_GREEN_MASK      = 3'd3,
        REG_BLUE_MASK       = 3'd4,
        REG_ALPHA_MASK      = 3'd5,
        REG_ALPHA_ENABLE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_MASKED,
        OP_PAL_READ,
        OP_PAL_WRITE
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] pixel;
        logic [7:0]  index;
        logic [23:0] color;
    } op_t;

    typedef struct packed {
        logic                          palette_mode;
        logic [2:0]                    bytes_per_pixel;
        logic [NUM_CH-1:0][31:0]       mask;
        logic                          alpha_enable;
    } cfg_t;

    function automatic logic [5:0] pop32(input logic [31:0] m);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++) begin
            l1[i] = {1'b0, m[2*i]} + {1'b0, m[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

    function automatic logic [4:0] low_pos(input logic [31:0] m);
        logic [4:0] p;
        p = '0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [31:0] recip(input logic [2:0] n);
        logic [31:0] r;
        unique case (n)
            3'd1:    r = RECIP_1;
            3'd2:    r = RECIP_3;
            3'd3:    r = RECIP_7;
            3'd4:    r = RECIP_15;
            3'd5:    r = RECIP_31;
            3'd6:    r = RECIP_63;
            3'd7:    r = RECIP_127;
            default: r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/bp2rgba_front.sv @@
module bp2rgba_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               palette_mode,
    output logic               push_valid,
    output bp2rgba_pkg::op_t   push_data,
    input  logic               push_ready
);

    logic             valid_reg;
    bp2rgba_pkg::op_t op_reg;
    bp2rgba_pkg::op_t op_next;

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = op_reg;

    always_comb begin
        op_next.pixel = s_tdata[31:0];
        op_next.index = s_tdata[39:32];
        op_next.color = s_tdata[63:40];
        priority if (s_tuser) begin
            op_next.kind = bp2rgba_pkg::OP_PAL_WRITE;
        end else if (palette_mode) begin
            op_next.kind = bp2rgba_pkg::OP_PAL_READ;
        end else begin
            op_next.kind = bp2rgba_pkg::OP_MASKED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= op_next;
        end
    end

endmodule

@@ hw/rtl/bp2rgba_fifo.sv @@
module bp2rgba_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  bp2rgba_pkg::op_t   push_data,
    output logic               push_ready,
    output logic               pop_valid,
    output bp2rgba_pkg::op_t   pop_data,
    input  logic               pop_ready
);

    localparam int PW = bp2rgba_pkg::FIFO_PTR_W;
    localparam int CW = bp2rgba_pkg::FIFO_PTR_W + 1;

    bp2rgba_pkg::op_t slot_reg [bp2rgba_pkg::FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CW'(bp2rgba_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(bp2rgba_pkg::FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(bp2rgba_pkg::FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/bp2rgba_back.sv @@
module bp2rgba_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  bp2rgba_pkg::cfg_t  cfg,
    input  logic               pop_valid,
    input  bp2rgba_pkg::op_t   pop_data,
    output logic               pop_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata
);

    localparam int NC = bp2rgba_pkg::NUM_CH;
    localparam int IW = bp2rgba_pkg::PAL_IDX_W;

    logic [23:0] pal_mem [bp2rgba_pkg::PAL_ENTRIES];

    logic [NC-1:0][4:0]  pos_reg;
    logic [NC-1:0][5:0]  cnt_reg;
    logic                alpha_force_reg;

    logic                en;
    logic                pop;
    logic [31:0]         pix_keep;
    logic [31:0]         pix_in;
    logic                rd_ok;
    logic                wr_ok;
    logic [NC-1:0][31:0] v_next;
    logic [NC-1:0][31:0] x_next;

    logic                p1_valid_reg;
    logic                p1_pal_reg;
    logic                p1_pal_ok_reg;
    logic [23:0]         rd_data_reg;
    logic [NC-1:0][31:0] p1_v_reg;
    logic [NC-1:0][31:0] p1_x_reg;

    logic [NC-1:0][31:0] q0_next;
    logic [NC-1:0][7:0]  wide_next;
    logic [63:0]         prod;
    logic [5:0]          sh;

    logic                p2_valid_reg;
    logic                p2_pal_reg;
    logic [23:0]         p2_color_reg;
    logic [NC-1:0][31:0] p2_q0_reg;
    logic [NC-1:0][31:0] p2_x_reg;
    logic [NC-1:0][7:0]  p2_wide_reg;

    logic [NC-1:0][7:0]  res_next;
    logic [31:0]         out_next;
    logic [6:0]          dv;
    logic [31:0]         qd;
    logic [31:0]         rem;
    logic [31:0]         q;

    logic                out_valid_reg;
    logic [31:0]         out_data_reg;

    assign en        = !out_valid_reg || m_tready;
    assign pop_ready = en;
    assign pop       = en && pop_valid;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NC; c++) begin
            pos_reg[c] <= bp2rgba_pkg::low_pos(cfg.mask[c]);
            cnt_reg[c] <= bp2rgba_pkg::pop32(cfg.mask[c]);
        end
        alpha_force_reg <= !cfg.alpha_enable || (cfg.mask[bp2rgba_pkg::CH_ALPHA] == '0);
    end

    always_comb begin
        unique case (cfg.bytes_per_pixel)
            3'd3, 3'd4, 3'd5, 3'd6, 3'd7: begin
                pix_keep = (cfg.bytes_per_pixel == 3'd3) ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
            end
            default: pix_keep = 32'h0000_FFFF;
        endcase
        pix_in = pop_data.pixel & pix_keep;
        for (int c = 0; c < NC; c++) begin
            v_next[c] = (pix_in & cfg.mask[c]) >> pos_reg[c];
            x_next[c] = (v_next[c] << 8) - v_next[c];
        end
    end

    assign rd_ok = {1'b0, pop_data.pixel[7:0]} < 9'(bp2rgba_pkg::PAL_ENTRIES);
    assign wr_ok = {1'b0, pop_data.index} < 9'(bp2rgba_pkg::PAL_ENTRIES);

    always_ff @(posedge aclk) begin
        if (pop && (pop_data.kind == bp2rgba_pkg::OP_PAL_WRITE) && wr_ok) begin
            pal_mem[pop_data.index[IW-1:0]] <= pop_data.color;
        end
        if (en) begin
            rd_data_reg <= pal_mem[pop_data.pixel[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= pop && (pop_data.kind != bp2rgba_pkg::OP_PAL_WRITE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_pal_reg    <= pop_data.kind == bp2rgba_pkg::OP_PAL_READ;
            p1_pal_ok_reg <= rd_ok;
            p1_v_reg      <= v_next;
            p1_x_reg      <= x_next;
        end
    end

    always_comb begin
        prod = '0;
        sh   = '0;
        for (int c = 0; c < NC; c++) begin
            prod         = {32'b0, p1_x_reg[c]} * {32'b0, bp2rgba_pkg::recip(cnt_reg[c][2:0])};
            q0_next[c]   = prod[63:32];
            sh           = cnt_reg[c] - 6'd8;
            wide_next[c] = 8'(p1_v_reg[c] >> sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_pal_reg   <= p1_pal_reg;
            p2_color_reg <= p1_pal_ok_reg ? rd_data_reg : '0;
            p2_q0_reg    <= q0_next;
            p2_x_reg     <= p1_x_reg;
            p2_wide_reg  <= wide_next;
        end
    end

    always_comb begin
        dv  = '0;
        qd  = '0;
        rem = '0;
        q   = '0;
        for (int c = 0; c < NC; c++) begin
            dv  = 7'((8'd1 << cnt_reg[c][2:0]) - 8'd1);
            qd  = p2_q0_reg[c] * {25'b0, dv};
            rem = p2_x_reg[c] - qd;
            q   = (rem >= {25'b0, dv}) ? p2_q0_reg[c] + 32'd1 : p2_q0_reg[c];
            priority if (cnt_reg[c] == '0) begin
                res_next[c] = '0;
            end else if (cnt_reg[c] >= 6'd8) begin
                res_next[c] = p2_wide_reg[c];
            end else begin
                res_next[c] = q[7:0];
            end
        end
        if (p2_pal_reg) begin
            out_next = {8'hFF, p2_color_reg};
        end else begin
            out_next = {alpha_force_reg ? 8'hFF : res_next[bp2rgba_pkg::CH_ALPHA],
                        res_next[bp2rgba_pkg::CH_BLUE],
                        res_next[bp2rgba_pkg::CH_GREEN],
                        res_next[bp2rgba_pkg::CH_RED]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_next;
        end
    end

endmodule

@@ hw/rtl/bitmask_pixel_to_rgba8.sv @@
// Converts one packed pixel per request to 8-bit RGBA and sustains one request per clock while
// the result side is not stalled, palette writes included; a converted pixel is offered once
// its request passes the front register (loaded on the accepting edge), one queue slot and
// three back stages, and a palette write gives no result. The pace is set by the per-channel
// reciprocal multiplier and the palette RAM's write and read ports, each used at most once per
// request. Palette entries hold nothing defined until written. The user must write registers
// through the cfg_wr port only while no request is in flight; the block does not enforce this.
module bitmask_pixel_to_rgba8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // pixel_word[31:0], entry_index[39:32], entry_color[63:40]
    input  logic        s_tuser,     // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data
);

    bp2rgba_pkg::cfg_t cfg_reg;
    bp2rgba_pkg::cfg_t cfg_next;

    logic              push_valid;
    logic              push_ready;
    bp2rgba_pkg::op_t  push_data;
    logic              pop_valid;
    logic              pop_ready;
    bp2rgba_pkg::op_t  pop_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                bp2rgba_pkg::REG_PALETTE_MODE:    cfg_next.palette_mode = cfg_wr_data[0];
                bp2rgba_pkg::REG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_wr_data[2:0];
                bp2rgba_pkg::REG_RED_MASK: begin
                    cfg_next.mask[bp2rgba_pkg::CH_RED] = cfg_wr_data;
                end
                bp2rgba_pkg::REG_GREEN_MASK: begin
                    cfg_next.mask[bp2rgba_pkg::CH_GREEN] = cfg_wr_data;
                end
                bp2rgba_pkg::REG_BLUE_MASK: begin
                    cfg_next.mask[bp2rgba_pkg::CH_BLUE] = cfg_wr_data;
                end
                bp2rgba_pkg::REG_ALPHA_MASK: begin
                    cfg_next.mask[bp2rgba_pkg::CH_ALPHA] = cfg_wr_data;
                end
                bp2rgba_pkg::REG_ALPHA_ENABLE:    cfg_next.alpha_enable = cfg_wr_data[0];
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.palette_mode                   <= 1'b0;
            cfg_reg.bytes_per_pixel                <= 3'd4;
            cfg_reg.mask[bp2rgba_pkg::CH_RED]      <= 32'h00FF_0000;
            cfg_reg.mask[bp2rgba_pkg::CH_GREEN]    <= 32'h0000_FF00;
            cfg_reg.mask[bp2rgba_pkg::CH_BLUE]     <= 32'h0000_00FF;
            cfg_reg.mask[bp2rgba_pkg::CH_ALPHA]    <= 32'hFF00_0000;
            cfg_reg.alpha_enable                   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bp2rgba_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .palette_mode (cfg_reg.palette_mode),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .push_ready   (push_ready)
    );

    bp2rgba_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    bp2rgba_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
